FILE: rtl/assert_macros.svh
// Assertion macros shared by the calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcalc_pkg.sv
// Types, key codes and helper functions for the calculator key engine.
`timescale 1ns / 1ps

package fcalc_pkg;

  localparam int VAL_W = 17;

  localparam logic [4:0] KEY_D0  = 5'd0;
  localparam logic [4:0] KEY_D9  = 5'd9;
  localparam logic [4:0] KEY_ADD = 5'd10;
  localparam logic [4:0] KEY_SUB = 5'd11;
  localparam logic [4:0] KEY_MUL = 5'd12;
  localparam logic [4:0] KEY_DIV = 5'd13;
  localparam logic [4:0] KEY_EQ  = 5'd14;
  localparam logic [4:0] KEY_CLR = 5'd15;
  localparam logic [4:0] KEY_CE  = 5'd16;
  localparam logic [4:0] KEY_BSP = 5'd17;
  localparam logic [4:0] KEY_NEG = 5'd18;

  localparam logic signed [VAL_W-1:0] RADIX = 17'sd10;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_MUL = 3'd2,
    ALU_DIV = 3'd3,
    ALU_DIG = 3'd4
  } alu_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_KEY   = 2'd3
  } status_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } alu_rsp_t;

  function automatic op_t key_to_op(logic [4:0] key);
    op_t op;
    case (key)
      KEY_ADD: op = OP_ADD;
      KEY_SUB: op = OP_SUB;
      KEY_MUL: op = OP_MUL;
      KEY_DIV: op = OP_DIV;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic alu_op_t op_to_alu(op_t op);
    alu_op_t aop;
    case (op)
      OP_SUB:  aop = ALU_SUB;
      OP_MUL:  aop = ALU_MUL;
      OP_DIV:  aop = ALU_DIV;
      default: aop = ALU_ADD;
    endcase
    return aop;
  endfunction

endpackage

FILE: rtl/fcalc_alu.sv
// Shared arithmetic unit: one 35-bit adder, serial multiply and restoring divide.
`timescale 1ns / 1ps

module fcalc_alu (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fcalc_pkg::alu_req_t    req,
  input  logic signed [16:0]     a,
  input  logic signed [16:0]     b,
  output fcalc_pkg::alu_rsp_t    rsp,
  output logic signed [16:0]     res
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_RUN  = 4'b0010,
    A_FIX  = 4'b0100,
    A_DONE = 4'b1000
  } astate_t;

  localparam logic [4:0] CNT_LAST = 5'(fcalc_pkg::VAL_W - 1);

  astate_t     state_r, state_nxt;
  logic [33:0] acc_r;
  logic [33:0] mcand_r;
  logic [16:0] mplier_r;   // multiplier, or dividend shifting into quotient
  logic [17:0] rem_r;
  logic [16:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic        is_div_r;
  logic        divz_r;
  logic [34:0] res_r;

  logic [34:0] a35, b35;
  logic [16:0] mag_a, mag_b;
  logic [17:0] rem_sh;
  logic [34:0] add_x, add_y, sum;
  logic        add_sub;
  logic        in_rng;

  assign a35    = {{18{a[16]}}, a};
  assign b35    = {{18{b[16]}}, b};
  // -(-65536) in 17 bits is 0x10000, the right unsigned magnitude
  assign mag_a  = a[16] ? (~a + 17'd1) : a;
  assign mag_b  = b[16] ? (~b + 17'd1) : b;
  assign rem_sh = {rem_r[16:0], mplier_r[16]};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_r)
      A_IDLE: begin
        add_x   = a35;
        add_y   = b35;
        add_sub = (req.op == fcalc_pkg::ALU_SUB);
        if (req.op == fcalc_pkg::ALU_DIG) begin
          // a*10 + digit
          add_x = a35 << 3;
          add_y = (a35 << 1) + b35;
        end
      end
      A_RUN: begin
        if (is_div_r) begin
          add_x   = {17'b0, rem_sh};
          add_y   = {18'b0, dvs_r};
          add_sub = 1'b1;
        end else begin
          add_x = {1'b0, acc_r};
          add_y = mplier_r[0] ? {1'b0, mcand_r} : '0;
        end
      end
      A_FIX: begin
        add_y   = is_div_r ? {18'b0, mplier_r} : {1'b0, acc_r};
        add_sub = neg_r;
      end
      default: ;
    endcase
  end

  assign sum = add_x + (add_sub ? ~add_y : add_y) + {34'b0, add_sub};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          if (req.op == fcalc_pkg::ALU_MUL ||
              (req.op == fcalc_pkg::ALU_DIV && b != '0)) state_nxt = A_RUN;
          else state_nxt = A_DONE;
        end
      end
      A_RUN:   if (cnt_r == CNT_LAST) state_nxt = A_FIX;
      A_FIX:   state_nxt = A_DONE;
      A_DONE:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        cnt_r  <= '0;
        neg_r  <= a[16] ^ b[16];
        divz_r <= 1'b0;
        if (req.start) begin
          case (req.op)
            fcalc_pkg::ALU_MUL: begin
              acc_r    <= '0;
              mcand_r  <= {17'b0, mag_a};
              mplier_r <= mag_b;
              is_div_r <= 1'b0;
            end
            fcalc_pkg::ALU_DIV: begin
              rem_r    <= '0;
              mplier_r <= mag_a;
              dvs_r    <= mag_b;
              is_div_r <= 1'b1;
              if (b == '0) begin
                divz_r <= 1'b1;
                res_r  <= '0;
              end
            end
            default: res_r <= sum;
          endcase
        end
      end
      A_RUN: begin
        cnt_r <= cnt_r + 5'd1;
        if (is_div_r) begin
          if (!sum[34]) begin
            rem_r    <= sum[17:0];
            mplier_r <= {mplier_r[15:0], 1'b1};
          end else begin
            rem_r    <= rem_sh;
            mplier_r <= {mplier_r[15:0], 1'b0};
          end
        end else begin
          acc_r    <= sum[33:0];
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
      end
      A_FIX:   res_r <= sum;
      default: ;
    endcase
  end

  // in range when bits 34..16 are all sign
  assign in_rng = (&res_r[34:16]) || !(|res_r[34:16]);

  always_comb begin
    rsp.done   = (state_r == A_DONE);
    rsp.status = fcalc_pkg::ST_OK;
    if (divz_r) rsp.status = fcalc_pkg::ST_DIVZ;
    else if (!in_rng) rsp.status = fcalc_pkg::ST_RANGE;
  end

  assign res = signed'(res_r[16:0]);

endmodule

FILE: rtl/four_function_calculator_keys.sv
// Top level of the calculator key engine: key sequencer, operand state, result register.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_key_code[4:0]
//   out_     output     out_valid/out_stall out_display_value[16:0], out_status[1:0]
//
// One key at a time. Clear, clear entry, operator/equals without a computation
// and invalid keys go from decode straight to emit; add, subtract, negate,
// digits and a divide by zero take one pass through the shared adder;
// multiply, divide and backspace run the 17-step serial loop of the shared ALU.
// Synchronous active-low reset clears all operand and mode state at once.
// A result waits in the output register; the next key is taken meanwhile and
// its result is held until out_stall drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_function_calculator_keys (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_key_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_display_value,
  output logic [1:0]         out_status
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_WAIT   = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [4:0]           key_r, key_nxt;
  logic signed [16:0]   left_r, left_nxt;
  logic signed [16:0]   right_r, right_nxt;
  logic signed [16:0]   shown_r, shown_nxt;
  fcalc_pkg::op_t       pend_r, pend_nxt;
  logic                 seen_r, seen_nxt;
  logic                 just_r, just_nxt;
  logic                 aeq_r, aeq_nxt;
  fcalc_pkg::status_t   status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [16:0]   disp_out_r, disp_out_nxt;
  fcalc_pkg::status_t   stat_out_r, stat_out_nxt;

  fcalc_pkg::alu_req_t  alu_req;
  fcalc_pkg::alu_rsp_t  alu_rsp;
  logic signed [16:0]   alu_a, alu_b, alu_res;
  logic signed [16:0]   opnd;
  logic                 clr;

  fcalc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  // operand that clear entry, backspace, negate and digits work on
  assign opnd = (pend_r != fcalc_pkg::OP_NONE) ? right_r : left_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    shown_nxt     = shown_r;
    pend_nxt      = pend_r;
    seen_nxt      = seen_r;
    just_nxt      = just_r;
    aeq_nxt       = aeq_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    disp_out_nxt  = disp_out_r;
    stat_out_nxt  = stat_out_r;
    alu_req.start = 1'b0;
    alu_req.op    = fcalc_pkg::ALU_ADD;
    alu_a         = opnd;
    alu_b         = right_r;
    clr           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_key_code;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = fcalc_pkg::ST_OK;
        state_nxt  = S_EMIT;
        case (key_r) inside
          [fcalc_pkg::KEY_D0 : fcalc_pkg::KEY_D9]: begin
            // digit after equals starts over on a cleared left operand
            clr           = aeq_r;
            alu_req.start = 1'b1;
            alu_req.op    = fcalc_pkg::ALU_DIG;
            alu_a         = aeq_r ? '0 : opnd;
            alu_b         = {12'b0, key_r};
            state_nxt     = S_WAIT;
          end
          [fcalc_pkg::KEY_ADD : fcalc_pkg::KEY_DIV]: begin
            if (just_r) begin
              pend_nxt = fcalc_pkg::key_to_op(key_r);
            end else if (seen_r && aeq_r) begin
              pend_nxt  = fcalc_pkg::key_to_op(key_r);
              aeq_nxt   = 1'b0;
              right_nxt = '0;
            end else if (seen_r) begin
              alu_req.start = 1'b1;
              alu_req.op    = fcalc_pkg::op_to_alu(pend_r);
              alu_a         = left_r;
              alu_b         = right_r;
              state_nxt     = S_WAIT;
            end else begin
              pend_nxt = fcalc_pkg::key_to_op(key_r);
              seen_nxt = 1'b1;
              just_nxt = 1'b1;
              aeq_nxt  = 1'b0;
            end
          end
          fcalc_pkg::KEY_EQ: begin
            if (!just_r) begin
              if (!seen_r) begin
                shown_nxt = left_r;
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = fcalc_pkg::op_to_alu(pend_r);
                alu_a         = left_r;
                alu_b         = right_r;
                state_nxt     = S_WAIT;
              end
            end
          end
          fcalc_pkg::KEY_CLR: clr = 1'b1;
          fcalc_pkg::KEY_CE: begin
            if (!just_r) begin
              if (!aeq_r) begin
                if (pend_r != fcalc_pkg::OP_NONE) right_nxt = '0;
                else left_nxt = '0;
              end
              shown_nxt = '0;
            end
          end
          fcalc_pkg::KEY_BSP: begin
            alu_req.start = 1'b1;
            alu_req.op    = fcalc_pkg::ALU_DIV;
            alu_a         = opnd;
            alu_b         = fcalc_pkg::RADIX;
            state_nxt     = S_WAIT;
          end
          fcalc_pkg::KEY_NEG: begin
            alu_req.start = 1'b1;
            alu_req.op    = fcalc_pkg::ALU_SUB;
            alu_a         = '0;
            alu_b         = opnd;
            state_nxt     = S_WAIT;
          end
          default: status_nxt = fcalc_pkg::ST_KEY;
        endcase
      end

      S_WAIT: begin
        if (alu_rsp.done) begin
          state_nxt = S_EMIT;
          if (alu_rsp.status != fcalc_pkg::ST_OK) begin
            clr        = 1'b1;
            status_nxt = alu_rsp.status;
          end else begin
            case (key_r) inside
              [fcalc_pkg::KEY_ADD : fcalc_pkg::KEY_DIV]: begin
                left_nxt  = alu_res;
                shown_nxt = alu_res;
                right_nxt = '0;
                pend_nxt  = fcalc_pkg::key_to_op(key_r);
                seen_nxt  = 1'b1;
                just_nxt  = 1'b1;
                aeq_nxt   = 1'b0;
              end
              fcalc_pkg::KEY_EQ: begin
                left_nxt  = alu_res;
                shown_nxt = alu_res;
                aeq_nxt   = 1'b1;
              end
              default: begin
                // digit, backspace, negate: write back the chosen operand
                if (pend_r != fcalc_pkg::OP_NONE) right_nxt = alu_res;
                else left_nxt = alu_res;
                shown_nxt = alu_res;
                if (key_r <= fcalc_pkg::KEY_D9) just_nxt = 1'b0;
              end
            endcase
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          disp_out_nxt  = shown_r;
          stat_out_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (clr) begin
      left_nxt  = '0;
      right_nxt = '0;
      shown_nxt = '0;
      pend_nxt  = fcalc_pkg::OP_NONE;
      seen_nxt  = 1'b0;
      just_nxt  = 1'b0;
      aeq_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      shown_r     <= '0;
      pend_r      <= fcalc_pkg::OP_NONE;
      seen_r      <= 1'b0;
      just_r      <= 1'b0;
      aeq_r       <= 1'b0;
      status_r    <= fcalc_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      shown_r     <= shown_nxt;
      pend_r      <= pend_nxt;
      seen_r      <= seen_nxt;
      just_r      <= just_nxt;
      aeq_r       <= aeq_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    disp_out_r <= disp_out_nxt;
    stat_out_r <= stat_out_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_display_value = disp_out_r;
  assign out_status        = stat_out_r;

  `FC_ASSERT_NXT(a_accept_decodes, in_valid && !in_stall, state_r == S_DECODE, "item not decoded")
  `FC_ASSERT_IMP(a_alu_done_waited, alu_rsp.done, state_r == S_WAIT, "ALU result not awaited")
  `FC_ASSERT_IMP(a_error_zero, out_valid && (out_status == fcalc_pkg::ST_RANGE || out_status == fcalc_pkg::ST_DIVZ), out_display_value == '0, "error result not cleared")
  `FC_ASSERT_NXT(a_emit_loads, state_r == S_EMIT && !(out_valid && out_stall), out_valid && state_r == S_IDLE, "result not loaded")

endmodule
